// File: rtl/lcgrng_pkg.sv
// Types, constants and the control store of the range-limited LCG block.
package lcgrng_pkg;

    localparam int WORD_W  = 32;
    localparam int RANGE_W = 31;
    localparam int STEP_W  = 4;
    localparam int CNT_W   = 5;
    localparam int INDEX_W = 2;

    localparam logic [INDEX_W-1:0] REG_MULTIPLIER = 2'd0;
    localparam logic [INDEX_W-1:0] REG_INCREMENT  = 2'd1;
    localparam logic [INDEX_W-1:0] REG_MODULUS    = 2'd2;

    localparam logic [WORD_W-1:0] MULTIPLIER_RESET = 32'd1093;
    localparam logic [WORD_W-1:0] INCREMENT_RESET  = 32'd221587;
    localparam logic [WORD_W-1:0] MODULUS_RESET    = 32'd1048576;

    localparam logic FUNC_DRAW = 1'b0;
    localparam logic FUNC_SEED = 1'b1;

    typedef logic [STEP_W-1:0] step_t;

    typedef enum logic [3:0] {
        UOP_NOP,
        UOP_LOAD_SEED,
        UOP_MUL_RANGE,
        UOP_MUL_AX,
        UOP_ADD_C,
        UOP_DIV_INIT,
        UOP_DIV_STEP,
        UOP_SAVE_SCALED,
        UOP_SAVE_STATE,
        UOP_EMIT
    } uop_t;

    typedef enum logic [1:0] {
        HOLD_NONE,
        HOLD_NO_REQ,
        HOLD_DIV_MORE,
        HOLD_OUT_BUSY
    } hold_t;

    typedef enum logic [1:0] {
        JUMP_NONE,
        JUMP_ALWAYS,
        JUMP_SEED
    } jump_t;

    typedef struct packed {
        uop_t  uop;
        hold_t hold;
        jump_t jump;
        step_t target;
    } uword_t;

    localparam step_t STEP_WAIT        = 4'd0;
    localparam step_t STEP_DISPATCH    = 4'd1;
    localparam step_t STEP_MUL_RANGE   = 4'd2;
    localparam step_t STEP_DIV1_INIT   = 4'd3;
    localparam step_t STEP_DIV1_LOOP   = 4'd4;
    localparam step_t STEP_SAVE_SCALED = 4'd5;
    localparam step_t STEP_MUL_AX      = 4'd6;
    localparam step_t STEP_ADD_C       = 4'd7;
    localparam step_t STEP_LOAD_SEED   = 4'd8;
    localparam step_t STEP_DIV2_INIT   = 4'd9;
    localparam step_t STEP_DIV2_LOOP   = 4'd10;
    localparam step_t STEP_SAVE_STATE  = 4'd11;
    localparam step_t STEP_EMIT        = 4'd12;

    function automatic uword_t ucode_rom(input step_t step);
        uword_t w;
        unique case (step)
            STEP_WAIT:        w = '{UOP_NOP,         HOLD_NO_REQ,   JUMP_NONE,   STEP_WAIT};
            STEP_DISPATCH:    w = '{UOP_NOP,         HOLD_NONE,     JUMP_SEED,   STEP_LOAD_SEED};
            STEP_MUL_RANGE:   w = '{UOP_MUL_RANGE,   HOLD_NONE,     JUMP_NONE,   STEP_WAIT};
            STEP_DIV1_INIT:   w = '{UOP_DIV_INIT,    HOLD_NONE,     JUMP_NONE,   STEP_WAIT};
            STEP_DIV1_LOOP:   w = '{UOP_DIV_STEP,    HOLD_DIV_MORE, JUMP_NONE,   STEP_WAIT};
            STEP_SAVE_SCALED: w = '{UOP_SAVE_SCALED, HOLD_NONE,     JUMP_NONE,   STEP_WAIT};
            STEP_MUL_AX:      w = '{UOP_MUL_AX,      HOLD_NONE,     JUMP_NONE,   STEP_WAIT};
            STEP_ADD_C:       w = '{UOP_ADD_C,       HOLD_NONE,     JUMP_ALWAYS, STEP_DIV2_INIT};
            STEP_LOAD_SEED:   w = '{UOP_LOAD_SEED,   HOLD_NONE,     JUMP_NONE,   STEP_WAIT};
            STEP_DIV2_INIT:   w = '{UOP_DIV_INIT,    HOLD_NONE,     JUMP_NONE,   STEP_WAIT};
            STEP_DIV2_LOOP:   w = '{UOP_DIV_STEP,    HOLD_DIV_MORE, JUMP_NONE,   STEP_WAIT};
            STEP_SAVE_STATE:  w = '{UOP_SAVE_STATE,  HOLD_NONE,     JUMP_NONE,   STEP_WAIT};
            STEP_EMIT:        w = '{UOP_EMIT,        HOLD_OUT_BUSY, JUMP_ALWAYS, STEP_WAIT};
            default:          w = '{UOP_NOP,         HOLD_NONE,     JUMP_ALWAYS, STEP_WAIT};
        endcase
        return w;
    endfunction

endpackage

// File: rtl/lcg_random_range_generator.sv
// Range-limited linear congruential generator: control store sequencer and datapath.
//
// Each request either loads a seed (tuser high) or draws a value (tuser low), and gives
// exactly one result. A draw returns the current state and range * state / modulus,
// then advances the state to (multiplier * state + increment) mod modulus; a modulus of
// zero acts as 2^32. Both kinds of request run through the shared divider, which retires
// two quotient bits a cycle on each 64-by-32 division (a draw needs two, a seed load
// one). Requests are taken only while the sequencer waits at its first step; the result
// register lets the next request in while a result is still waiting, and a result that
// cannot leave holds the sequencer at its last step.
module lcg_random_range_generator
    import lcgrng_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,

    input  logic                cfg_wr_en,
    input  logic [INDEX_W-1:0]  cfg_index,
    input  logic [WORD_W-1:0]   cfg_wdata,

    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [63:0]         s_axis_tdata,   // seed_value[31:0], draw_range[62:32], zero
    input  logic                s_axis_tuser,   // func

    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [63:0]         m_axis_tdata    // raw_value[31:0], scaled_value[62:32], zero
);

    logic [WORD_W-1:0]   mult_reg, incr_reg, modulus_reg, x_reg;
    logic [WORD_W-1:0]   mult_next, incr_next, modulus_next, x_next;
    step_t               pc_reg, pc_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                out_valid_reg, out_valid_next;

    logic                func_reg, func_next;
    logic [WORD_W-1:0]   seed_reg, seed_next;
    logic [RANGE_W-1:0]  range_reg, range_next;
    logic [63:0]         prod_reg, prod_next;
    logic [63:0]         dvd_reg, dvd_next;
    logic [WORD_W:0]     rem_reg, rem_next;
    logic [WORD_W-1:0]   raw_res_reg, raw_res_next;
    logic [RANGE_W-1:0]  scaled_res_reg, scaled_res_next;
    logic [WORD_W-1:0]   out_raw_reg, out_raw_next;
    logic [RANGE_W-1:0]  out_scaled_reg, out_scaled_next;

    uword_t              uw;
    logic                in_accept;
    logic                out_free;
    logic                hold_now;
    logic                jump_now;
    logic                emit;

    logic [WORD_W:0]     divisor;
    logic [WORD_W+1:0]   t1, t2;
    logic                q1, q2;
    logic [WORD_W:0]     r1, r2;
    logic                sat;
    logic [RANGE_W-1:0]  scaled_calc;

    assign uw            = ucode_rom(pc_reg);
    assign s_axis_tready = (pc_reg == STEP_WAIT);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign emit          = (uw.uop == UOP_EMIT) && out_free;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_scaled_reg, out_raw_reg};

    // two restoring division steps per cycle, plus the scaled result limited to range - 1
    always_comb
    begin
        divisor = {(modulus_reg == '0), modulus_reg};
        t1 = {rem_reg, dvd_reg[63]};
        q1 = (t1 >= {1'b0, divisor});
        r1 = q1 ? (WORD_W + 1)'(t1 - {1'b0, divisor}) : t1[WORD_W:0];
        t2 = {r1, dvd_reg[62]};
        q2 = (t2 >= {1'b0, divisor});
        r2 = q2 ? (WORD_W + 1)'(t2 - {1'b0, divisor}) : t2[WORD_W:0];
        sat = (|dvd_reg[63:RANGE_W]) || (dvd_reg[RANGE_W-1:0] >= range_reg);
        if (range_reg == '0)
            scaled_calc = '0;
        else if (sat)
            scaled_calc = range_reg - RANGE_W'(1);
        else
            scaled_calc = dvd_reg[RANGE_W-1:0];
    end

    always_comb
    begin
        unique case (uw.hold)
            HOLD_NONE:     hold_now = 1'b0;
            HOLD_NO_REQ:   hold_now = !in_accept;
            HOLD_DIV_MORE: hold_now = (cnt_reg != '1);
            HOLD_OUT_BUSY: hold_now = !out_free;
            default:       hold_now = 1'b0;
        endcase
        unique case (uw.jump)
            JUMP_NONE:   jump_now = 1'b0;
            JUMP_ALWAYS: jump_now = 1'b1;
            JUMP_SEED:   jump_now = (func_reg == FUNC_SEED);
            default:     jump_now = 1'b0;
        endcase
        priority if (hold_now)
            pc_next = pc_reg;
        else if (jump_now)
            pc_next = uw.target;
        else
            pc_next = step_t'(pc_reg + 1'b1);
    end

    always_comb
    begin
        mult_next       = mult_reg;
        incr_next       = incr_reg;
        modulus_next    = modulus_reg;
        x_next          = x_reg;
        cnt_next        = cnt_reg;
        func_next       = func_reg;
        seed_next       = seed_reg;
        range_next      = range_reg;
        prod_next       = prod_reg;
        dvd_next        = dvd_reg;
        rem_next        = rem_reg;
        raw_res_next    = raw_res_reg;
        scaled_res_next = scaled_res_reg;
        out_raw_next    = out_raw_reg;
        out_scaled_next = out_scaled_reg;
        out_valid_next  = out_valid_reg;

        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_MULTIPLIER: mult_next    = cfg_wdata;
                REG_INCREMENT:  incr_next    = cfg_wdata;
                REG_MODULUS:    modulus_next = cfg_wdata;
                default:        ;
            endcase
        end

        if (in_accept)
        begin
            func_next  = s_axis_tuser;
            seed_next  = s_axis_tdata[WORD_W-1:0];
            range_next = s_axis_tdata[WORD_W+RANGE_W-1:WORD_W];
        end

        if (out_valid_reg && m_axis_tready)
            out_valid_next = 1'b0;

        unique case (uw.uop)
            UOP_NOP: ;
            UOP_LOAD_SEED:
            begin
                prod_next       = {32'd0, seed_reg};
                raw_res_next    = '0;
                scaled_res_next = '0;
            end
            UOP_MUL_RANGE:
                prod_next = {33'd0, range_reg} * {32'd0, x_reg};
            UOP_MUL_AX:
                prod_next = {32'd0, mult_reg} * {32'd0, x_reg};
            UOP_ADD_C:
                prod_next = prod_reg + {32'd0, incr_reg};
            UOP_DIV_INIT:
            begin
                dvd_next = prod_reg;
                rem_next = '0;
                cnt_next = '0;
            end
            UOP_DIV_STEP:
            begin
                dvd_next = {dvd_reg[61:0], q1, q2};
                rem_next = r2;
                cnt_next = CNT_W'(cnt_reg + 1'b1);
            end
            UOP_SAVE_SCALED:
            begin
                raw_res_next    = x_reg;
                scaled_res_next = scaled_calc;
            end
            UOP_SAVE_STATE:
                x_next = rem_reg[WORD_W-1:0];
            UOP_EMIT:
            begin
                if (emit)
                begin
                    out_raw_next    = raw_res_reg;
                    out_scaled_next = scaled_res_reg;
                    out_valid_next  = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mult_reg      <= MULTIPLIER_RESET;
            incr_reg      <= INCREMENT_RESET;
            modulus_reg   <= MODULUS_RESET;
            x_reg         <= '0;
            pc_reg        <= STEP_WAIT;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mult_reg      <= mult_next;
            incr_reg      <= incr_next;
            modulus_reg   <= modulus_next;
            x_reg         <= x_next;
            pc_reg        <= pc_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg       <= func_next;
        seed_reg       <= seed_next;
        range_reg      <= range_next;
        prod_reg       <= prod_next;
        dvd_reg        <= dvd_next;
        rem_reg        <= rem_next;
        raw_res_reg    <= raw_res_next;
        scaled_res_reg <= scaled_res_next;
        out_raw_reg    <= out_raw_next;
        out_scaled_reg <= out_scaled_next;
    end

    a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> pc_reg == STEP_DISPATCH)
        else $error("accepted request did not move to dispatch");

    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        (uw.uop == UOP_DIV_STEP) |=> cnt_reg == CNT_W'($past(cnt_reg) + 1'b1))
        else $error("divider step count did not advance");

    a_div_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (uw.uop == UOP_DIV_STEP && cnt_reg != '1) |=> pc_reg == $past(pc_reg))
        else $error("divider loop left early");

    a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> out_valid_reg && pc_reg == STEP_WAIT)
        else $error("result not presented after emit");

endmodule
